FILE: rtl/kmat_pkg.sv
// ----------------------------------------------------------------------------
// kmat_pkg
// Shared constants and types of the keyed mixed alphabet table.
// ----------------------------------------------------------------------------
package kmat_pkg;

  // Default alphabet size
  localparam int unsigned ALPHABET_SIZE_DEF = 26;

  // Input item kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_ROTATE = 2'd1;
  localparam logic [1:0] KIND_FWD    = 2'd2;
  localparam logic [1:0] KIND_INV    = 2'd3;

  // Answer kinds
  localparam logic ANSWER_FWD = 1'b0;
  localparam logic ANSWER_INV = 1'b1;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FILL = 6'b000010,
    ST_MOD  = 6'b000100,
    ST_FWD  = 6'b001000,
    ST_SCAN = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

endpackage

FILE: rtl/keyed_mixed_alphabet_table.sv
// ----------------------------------------------------------------------------
// keyed_mixed_alphabet_table
// Builds a keyword mixed alphabet in a table memory and answers forward and
// inverse lookups through a rotation offset.
// ----------------------------------------------------------------------------
// A key letter inside the alphabet is written straight into the table memory
// while a slot is free. The last key letter then fills the remaining slots,
// walking the letters in ascending order one per cycle. Rotate and forward
// lookups pass a remainder unit; a forward lookup then reads the table and
// hands the letter it finds to the output register. An inverse lookup reads
// the memory once per slot in rotated order and stops at the first match.
// The table memory has one write and one read port with a registered read;
// it is undefined after reset and needs no clearing pass. The next item is
// taken while a finished answer still waits on the output; an answer that
// finds the output still occupied waits in place and holds off the input
// until it moves on.
module keyed_mixed_alphabet_table #(
  parameter int unsigned ALPHABET_SIZE = kmat_pkg::ALPHABET_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [4:0]         key_letter_i,
  input  logic               key_last_i,
  input  logic signed [15:0] shift_amount_i,
  input  logic [4:0]         slot_index_i,
  input  logic [4:0]         query_letter_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [4:0]         letter_out_o,
  output logic [4:0]         position_out_o,
  output logic               letter_found_o,
  output logic               answer_kind_o
);

  localparam int unsigned IW      = $clog2(ALPHABET_SIZE);
  localparam int unsigned RotBias =
    ALPHABET_SIZE * ((32768 + ALPHABET_SIZE - 1) / ALPHABET_SIZE);
  localparam int unsigned TW      = $clog2(32767 + RotBias + ALPHABET_SIZE);
  localparam logic [IW-1:0] LastIdx = IW'(ALPHABET_SIZE - 1);

  // Table memory
  logic [IW-1:0] mem_q [ALPHABET_SIZE];
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] rd_data_q;

  // Control state
  kmat_pkg::state_e state_q, state_d;
  logic [ALPHABET_SIZE-1:0] used_q, used_d;
  logic [IW:0]   key_count_q, key_count_d;
  logic [IW-1:0] offset_q, offset_d;
  logic          loading_q, loading_d;
  logic [IW:0]   fill_letter_q, fill_letter_d;
  logic          mod_fwd_q, mod_fwd_d;
  logic [IW-1:0] scan_addr_q, scan_addr_d;
  logic [IW:0]   scan_cnt_q, scan_cnt_d;
  logic [IW-1:0] cmp_pos_q, cmp_pos_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [4:0]    query_q, query_d;

  // Pending answer and output register
  logic [4:0] res_letter_q, res_letter_d;
  logic [4:0] res_pos_q, res_pos_d;
  logic       res_found_q, res_found_d;
  logic       res_kind_q, res_kind_d;
  logic       out_valid_q, out_valid_d;
  logic       out_load;

  // Remainder unit
  logic          mod_start;
  logic [TW-1:0] mod_value;
  logic          mod_done;
  logic [IW-1:0] mod_rem;

  // Scratch for the key and scan paths
  logic                     in_accept;
  logic [IW:0]              eff_count;
  logic [ALPHABET_SIZE-1:0] eff_used;
  logic                     key_store;
  logic                     scan_hit;

  assign in_ready_o = (state_q == kmat_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  kmat_mod_unit #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .IW           (IW),
    .TW           (TW)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .value_i(mod_value),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // Sequence items through the table
  always_comb begin
    state_d       = state_q;
    used_d        = used_q;
    key_count_d   = key_count_q;
    offset_d      = offset_q;
    loading_d     = loading_q;
    fill_letter_d = fill_letter_q;
    mod_fwd_d     = mod_fwd_q;
    scan_addr_d   = scan_addr_q;
    scan_cnt_d    = scan_cnt_q;
    cmp_pos_d     = cmp_pos_q;
    cmp_vld_d     = 1'b0;
    query_d       = query_q;
    res_letter_d  = res_letter_q;
    res_pos_d     = res_pos_q;
    res_found_d   = res_found_q;
    res_kind_d    = res_kind_q;
    out_load      = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    mod_start     = 1'b0;
    mod_value     = '0;
    eff_count     = loading_q ? key_count_q : '0;
    eff_used      = loading_q ? used_q : '0;
    key_store     = (32'(key_letter_i) < ALPHABET_SIZE) &&
                    (32'(eff_count) < ALPHABET_SIZE);
    scan_hit      = cmp_vld_q && (32'(rd_data_q) == 32'(query_q));

    unique case (state_q)
      kmat_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (kind_i)
            kmat_pkg::KIND_KEY: begin
              // Start a new key when not loading, then store the letter if it is inside the alphabet and a slot is free
              if (!loading_q) begin
                offset_d = '0;
              end
              loading_d   = 1'b1;
              used_d      = eff_used;
              key_count_d = eff_count;
              if (key_store) begin
                wr_en       = 1'b1;
                wr_addr     = eff_count[IW-1:0];
                wr_data     = IW'(key_letter_i);
                used_d      = eff_used | (ALPHABET_SIZE'(1) << key_letter_i);
                key_count_d = eff_count + (IW+1)'(1);
              end
              if (key_last_i) begin
                fill_letter_d = '0;
                state_d       = kmat_pkg::ST_FILL;
              end
            end
            kmat_pkg::KIND_ROTATE: begin
              mod_start = 1'b1;
              mod_value = TW'(int'(shift_amount_i) + int'(RotBias) + int'(offset_q));
              mod_fwd_d = 1'b0;
              state_d   = kmat_pkg::ST_MOD;
            end
            kmat_pkg::KIND_FWD: begin
              mod_start = 1'b1;
              mod_value = TW'(int'(slot_index_i) + int'(offset_q));
              mod_fwd_d = 1'b1;
              state_d   = kmat_pkg::ST_MOD;
            end
            default: begin
              scan_addr_d = offset_q;
              scan_cnt_d  = '0;
              query_d     = query_letter_i;
              state_d     = kmat_pkg::ST_SCAN;
            end
          endcase
        end
      end

      kmat_pkg::ST_FILL: begin
        // Advance one letter a cycle and place it if the key left it unused
        if ((32'(key_count_q) < ALPHABET_SIZE) && (32'(fill_letter_q) < ALPHABET_SIZE)) begin
          if (!used_q[fill_letter_q[IW-1:0]]) begin
            wr_en       = 1'b1;
            wr_addr     = key_count_q[IW-1:0];
            wr_data     = fill_letter_q[IW-1:0];
            used_d      = used_q | (ALPHABET_SIZE'(1) << fill_letter_q);
            key_count_d = key_count_q + (IW+1)'(1);
          end
          fill_letter_d = fill_letter_q + (IW+1)'(1);
        end else begin
          loading_d = 1'b0;
          state_d   = kmat_pkg::ST_IDLE;
        end
      end

      kmat_pkg::ST_MOD: begin
        // Take the reduced offset or index
        if (mod_done) begin
          if (mod_fwd_q) begin
            rd_en   = 1'b1;
            rd_addr = mod_rem;
            state_d = kmat_pkg::ST_FWD;
          end else begin
            offset_d = mod_rem;
            state_d  = kmat_pkg::ST_IDLE;
          end
        end
      end

      kmat_pkg::ST_FWD: begin
        res_letter_d = 5'(rd_data_q);
        res_pos_d    = '0;
        res_found_d  = 1'b0;
        res_kind_d   = kmat_pkg::ANSWER_FWD;
        state_d      = kmat_pkg::ST_OUT;
      end

      kmat_pkg::ST_SCAN: begin
        // Compare the entry in flight and finish on a match or after the last slot, else issue the next rotated read
        res_letter_d = '0;
        res_kind_d   = kmat_pkg::ANSWER_INV;
        if (scan_hit) begin
          res_pos_d   = 5'(cmp_pos_q);
          res_found_d = 1'b1;
          state_d     = kmat_pkg::ST_OUT;
        end else if (cmp_vld_q && (cmp_pos_q == LastIdx)) begin
          res_pos_d   = '0;
          res_found_d = 1'b0;
          state_d     = kmat_pkg::ST_OUT;
        end else if (32'(scan_cnt_q) < ALPHABET_SIZE) begin
          rd_en       = 1'b1;
          rd_addr     = scan_addr_q;
          cmp_pos_d   = scan_cnt_q[IW-1:0];
          cmp_vld_d   = 1'b1;
          scan_addr_d = (scan_addr_q == LastIdx) ? '0 : scan_addr_q + IW'(1);
          scan_cnt_d  = scan_cnt_q + (IW+1)'(1);
        end
      end

      kmat_pkg::ST_OUT: begin
        // Hand the answer to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = kmat_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = kmat_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold the output item until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= kmat_pkg::ST_IDLE;
      used_q        <= '0;
      key_count_q   <= '0;
      offset_q      <= '0;
      loading_q     <= 1'b0;
      fill_letter_q <= '0;
      mod_fwd_q     <= 1'b0;
      scan_addr_q   <= '0;
      scan_cnt_q    <= '0;
      cmp_vld_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      used_q        <= used_d;
      key_count_q   <= key_count_d;
      offset_q      <= offset_d;
      loading_q     <= loading_d;
      fill_letter_q <= fill_letter_d;
      mod_fwd_q     <= mod_fwd_d;
      scan_addr_q   <= scan_addr_d;
      scan_cnt_q    <= scan_cnt_d;
      cmp_vld_q     <= cmp_vld_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmp_pos_q    <= cmp_pos_d;
    query_q      <= query_d;
    res_letter_q <= res_letter_d;
    res_pos_q    <= res_pos_d;
    res_found_q  <= res_found_d;
    res_kind_q   <= res_kind_d;
    if (out_load) begin
      letter_out_o   <= res_letter_q;
      position_out_o <= res_pos_q;
      letter_found_o <= res_found_q;
      answer_kind_o  <= res_kind_q;
    end
  end

  // Table memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_key_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(key_count_q) <= ALPHABET_SIZE)
    else $error("key count beyond alphabet size");

  a_offset_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(offset_q) < ALPHABET_SIZE)
    else $error("rotation offset out of range");

  a_write_no_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (!rd_en && ((state_q == kmat_pkg::ST_IDLE) ||
                          (state_q == kmat_pkg::ST_FILL))))
    else $error("table write outside key load or fill");

  a_mod_done_in_mod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == kmat_pkg::ST_MOD))
    else $error("remainder finished outside its wait state");

endmodule

FILE: rtl/kmat_mod_unit.sv
// ----------------------------------------------------------------------------
// kmat_mod_unit
// Remainder unit: reduces an unsigned word modulo the alphabet size by
// reciprocal multiplication, registering word, product and remainder.
// ----------------------------------------------------------------------------
module kmat_mod_unit #(
  parameter int unsigned ALPHABET_SIZE = kmat_pkg::ALPHABET_SIZE_DEF,
  parameter int unsigned IW            = $clog2(ALPHABET_SIZE),
  parameter int unsigned TW            = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [TW-1:0] value_i,
  output logic          done_o,
  output logic [IW-1:0] rem_o
);

  // Scaled reciprocal, exact for every TW-bit word
  localparam int unsigned K  = TW + IW;
  localparam int unsigned RW = TW + 1;
  localparam int unsigned PW = TW + RW;
  localparam logic [63:0] RecipWide =
    ((64'd1 << K) + 64'(ALPHABET_SIZE) - 64'd1) / 64'(ALPHABET_SIZE);
  localparam logic [RW-1:0] Recip   = RW'(RecipWide);
  localparam logic [TW-1:0] Modulus = TW'(ALPHABET_SIZE);

  logic [TW-1:0] val_q, val_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [IW-1:0] rem_q, rem_d;
  logic [TW-1:0] quo;
  logic [TW-1:0] rem_full;
  logic          load_q;
  logic          prod_vld_q;
  logic          done_q;

  // Hold the word from start until the remainder is taken
  assign val_d = start_i ? value_i : val_q;

  // Estimate the quotient, then subtract its multiple of the modulus
  assign prod_d   = PW'(val_q) * PW'(Recip);
  assign quo      = TW'(prod_q[PW-1:K]);
  assign rem_full = val_q - quo * Modulus;
  assign rem_d    = rem_full[IW-1:0];

  // Track the word through the load, product and remainder registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q     <= 1'b0;
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      load_q     <= start_i;
      prod_vld_q <= load_q;
      done_q     <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyed_mixed_alphabet_table. Key, rotate and lookup
// items are driven over the input handshake. A local alphabet predictor
// queues the answer expected for every lookup, and each answer taken from the
// output handshake is compared field by field against the oldest entry.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ASIZE = kmat_pkg::ALPHABET_SIZE_DEF;

  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         key_letter;
    logic               key_last;
    logic signed [15:0] shift;
    logic [4:0]         slot;
    logic [4:0]         query;
  } alpha_item_t;

  typedef struct packed {
    logic [4:0] letter;
    logic [4:0] position;
    logic       found;
    logic       kind;
  } answer_t;

  // Clock, reset and block ports
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_ready_o;
  logic [1:0]         kind_i         = '0;
  logic [4:0]         key_letter_i   = '0;
  logic               key_last_i     = 1'b0;
  logic signed [15:0] shift_amount_i = '0;
  logic [4:0]         slot_index_i   = '0;
  logic [4:0]         query_letter_i = '0;
  logic               out_valid_o;
  logic               out_ready      = 1'b0;
  logic [4:0]         letter_out_o;
  logic [4:0]         position_out_o;
  logic               letter_found_o;
  logic               answer_kind_o;

  // Alphabet predictor state
  logic [4:0]       alpha_model [ASIZE];
  logic [ASIZE-1:0] used_model  = '0;
  int unsigned      fill_count  = 0;
  int unsigned      rot_model   = 0;
  bit               key_open    = 1'b0;

  answer_t pending_answers [$];
  answer_t want_answer;
  int      fail_count  = 0;
  int      items_sent  = 0;
  int      stall_left  = 0;
  bit      steady_flow = 1'b0;

  keyed_mixed_alphabet_table uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .key_letter_i   (key_letter_i),
    .key_last_i     (key_last_i),
    .shift_amount_i (shift_amount_i),
    .slot_index_i   (slot_index_i),
    .query_letter_i (query_letter_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .letter_out_o   (letter_out_o),
    .position_out_o (position_out_o),
    .letter_found_o (letter_found_o),
    .answer_kind_o  (answer_kind_o)
  );

  always #2 clk_i = ~clk_i;

  // Advance the alphabet predictor by one accepted item
  task automatic predict_alphabet_item(input alpha_item_t it);
    answer_t     ans;
    int          s;
    int          m;
    int unsigned idx;
    ans = '0;
    case (it.kind)
      kmat_pkg::KIND_KEY: begin
        if (!key_open) begin
          fill_count = 0;
          used_model = '0;
          rot_model  = 0;
          key_open   = 1'b1;
        end
        if (it.key_letter < ASIZE && fill_count < ASIZE) begin
          alpha_model[fill_count] = it.key_letter;
          used_model[it.key_letter] = 1'b1;
          fill_count++;
        end
        // Fill the open slots with the unused letters, lowest first
        if (it.key_last) begin
          for (int l = 0; l < ASIZE; l++) begin
            if (!used_model[l] && fill_count < ASIZE) begin
              alpha_model[fill_count] = 5'(l);
              used_model[l] = 1'b1;
              fill_count++;
            end
          end
          key_open = 1'b0;
        end
      end
      kmat_pkg::KIND_ROTATE: begin
        s = int'(it.shift);
        m = s % int'(ASIZE);
        if (m < 0) m += int'(ASIZE);
        rot_model = (rot_model + int'(m)) % ASIZE;
      end
      kmat_pkg::KIND_FWD: begin
        idx = (int'(it.slot) + rot_model) % ASIZE;
        ans.letter = alpha_model[idx];
        ans.kind   = kmat_pkg::ANSWER_FWD;
        pending_answers.push_back(ans);
      end
      default: begin
        for (int i = 0; i < ASIZE; i++) begin
          idx = (i + rot_model) % ASIZE;
          if (!ans.found && alpha_model[idx] == it.query) begin
            ans.position = 5'(i);
            ans.found    = 1'b1;
          end
        end
        ans.kind = kmat_pkg::ANSWER_INV;
        pending_answers.push_back(ans);
      end
    endcase
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Letter, slot or query code: mostly inside the alphabet
  function automatic logic [4:0] pick_code();
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(ASIZE, 31));
    return 5'($urandom_range(0, ASIZE - 1));
  endfunction

  function automatic logic signed [15:0] pick_shift();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r < 5) return 16'($urandom_range(0, 60) - 30);
    return 16'($urandom);
  endfunction

  // Every field random; the item builders then set the ones that matter
  function automatic alpha_item_t rand_fields();
    alpha_item_t it;
    it.kind       = 2'($urandom_range(0, 3));
    it.key_letter = 5'($urandom_range(0, 31));
    it.key_last   = 1'($urandom_range(0, 1));
    it.shift      = 16'($urandom);
    it.slot       = 5'($urandom_range(0, 31));
    it.query      = 5'($urandom_range(0, 31));
    return it;
  endfunction

  function automatic alpha_item_t key_item(input logic [4:0] l, input logic last);
    alpha_item_t it;
    it            = rand_fields();
    it.kind       = kmat_pkg::KIND_KEY;
    it.key_letter = l;
    it.key_last   = last;
    return it;
  endfunction

  function automatic alpha_item_t rotate_item(input logic signed [15:0] sh);
    alpha_item_t it;
    it       = rand_fields();
    it.kind  = kmat_pkg::KIND_ROTATE;
    it.shift = sh;
    return it;
  endfunction

  function automatic alpha_item_t fwd_item(input logic [4:0] s);
    alpha_item_t it;
    it      = rand_fields();
    it.kind = kmat_pkg::KIND_FWD;
    it.slot = s;
    return it;
  endfunction

  function automatic alpha_item_t inv_item(input logic [4:0] q);
    alpha_item_t it;
    it       = rand_fields();
    it.kind  = kmat_pkg::KIND_INV;
    it.query = q;
    return it;
  endfunction

  function automatic alpha_item_t rand_op();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) return rotate_item(pick_shift());
    if (r < 5) return fwd_item(pick_code());
    return inv_item(pick_code());
  endfunction

  // Drive one item, hold it until accepted, then idle for a random gap, none in steady flow
  task automatic send_item(input alpha_item_t it);
    int gap;
    @(negedge clk_i);
    in_valid       <= 1'b1;
    kind_i         <= it.kind;
    key_letter_i   <= it.key_letter;
    key_last_i     <= it.key_last;
    shift_amount_i <= it.shift;
    slot_index_i   <= it.slot;
    query_letter_i <= it.query;
    do @(posedge clk_i); while (!in_ready_o);
    predict_alphabet_item(it);
    items_sent++;
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic pause_input();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  // Empty key: identity alphabet, extremes of index and query
  task automatic test_identity_key();
    send_item(key_item(5'd31, 1'b1));
    send_item(fwd_item(5'd0));
    send_item(fwd_item(5'd25));
    send_item(fwd_item(5'd31));
    send_item(inv_item(5'd0));
    send_item(inv_item(5'd25));
    send_item(inv_item(5'd31));
  endtask

  // Keyword with a repeated letter, closed by an out-of-alphabet letter
  task automatic test_keyword();
    send_item(key_item(5'd10, 1'b0));
    send_item(key_item(5'd4, 1'b0));
    send_item(key_item(5'd24, 1'b0));
    send_item(key_item(5'd4, 1'b0));
    send_item(key_item(5'd25, 1'b0));
    send_item(key_item(5'd26, 1'b1));
    send_item(fwd_item(5'd3));
    send_item(inv_item(5'd4));
    send_item(inv_item(5'd0));
  endtask

  // Rotation extremes and negative shifts
  task automatic test_rotation();
    send_item(rotate_item(16'sh7FFF));
    send_item(fwd_item(5'd0));
    send_item(rotate_item(16'sh8000));
    send_item(inv_item(5'd25));
    send_item(rotate_item(-16'sd1));
    send_item(fwd_item(5'd30));
  endtask

  // Rotate and look up while a new key is still loading
  task automatic test_loading();
    send_item(key_item(5'd0, 1'b0));
    send_item(rotate_item(16'sd5));
    send_item(fwd_item(5'd20));
    send_item(key_item(5'd1, 1'b1));
    send_item(inv_item(5'd1));
  endtask

  // One key of random length, then a run of rotates and lookups
  task automatic run_episode();
    int r;
    int key_len;
    int ops;
    r = $urandom_range(0, 99);
    if (r < 8) key_len = 0;
    else if (r < 80) key_len = $urandom_range(1, 10);
    else if (r < 94) key_len = $urandom_range(11, 25);
    else key_len = $urandom_range(26, 30);
    if (key_len == 0) begin
      send_item(key_item(5'($urandom_range(ASIZE, 31)), 1'b1));
    end
    for (int k = 0; k < key_len; k++) begin
      send_item(key_item(pick_code(), k == key_len - 1));
      if (k < key_len - 1 && $urandom_range(0, 11) == 0) send_item(rand_op());
    end
    ops = $urandom_range(2, 20);
    repeat (ops) send_item(rand_op());
  endtask

  task automatic test_random_traffic(input int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) run_episode();
  endtask

  // Let every answer come home, then resume
  task automatic test_drain_pause();
    pause_input();
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    send_item(inv_item(pick_code()));
    send_item(fwd_item(pick_code()));
  endtask

  // Back-to-back items with the output never stalled
  task automatic test_steady_flow(input int n);
    steady_flow = 1'b1;
    test_random_traffic(n);
    steady_flow = 1'b0;
  endtask

  // Output ready: random stalls unless in steady flow
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0 && !steady_flow) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = 0;
        if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each answer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("answer with none pending: letter %0d position %0d", letter_out_o,
               position_out_o);
        fail_count++;
      end else begin
        want_answer = pending_answers.pop_front();
        check_field("letter_out", want_answer.letter, letter_out_o);
        check_field("position_out", want_answer.position, position_out_o);
        check_field("letter_found", want_answer.found, letter_found_o);
        check_field("answer_kind", want_answer.kind, answer_kind_o);
      end
    end
  end

  // Bound the run
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_identity_key();
    test_keyword();
    test_rotation();
    test_loading();
    test_random_traffic(300);
    test_drain_pause();
    test_steady_flow(150);
    test_random_traffic(350);
    // Drain the output, then give the block time to settle
    pause_input();
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/kmat_pkg.sv
rtl/kmat_mod_unit.sv
rtl/keyed_mixed_alphabet_table.sv
tb/tb.sv
